>>> src/median_fire_detector_core_assert.svh
// ---------------------------------------------------------------------------
// Median fire detector - assertion macros
// Clocked concurrent assertion helpers used by the top level.
// ---------------------------------------------------------------------------
`ifndef MEDIAN_FIRE_DETECTOR_CORE_ASSERT_SVH
`define MEDIAN_FIRE_DETECTOR_CORE_ASSERT_SVH

// Same-cycle implication
`define MFD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define MFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/mfd_pkg.sv
// ---------------------------------------------------------------------------
// Median fire detector - package
// Shared widths, register indexes, reset values and inter-module structs.
// ---------------------------------------------------------------------------
package mfd_pkg;

  localparam int MEDIAN_LEN_DEF  = 5;
  localparam int HISTORY_LEN_DEF = 30;

  localparam int TEMP_W = 16;
  localparam int NEED_W = 5;
  localparam int RISE_W = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_TEMP_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_CNT_NEED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RISE_THR      = 2'd2;

  localparam logic signed [TEMP_W-1:0] HIGH_TEMP_THR_RST = 16'sd58;
  localparam logic [NEED_W-1:0]        HIGH_CNT_NEED_RST = 5'd27;
  localparam logic [RISE_W-1:0]        RISE_THR_RST      = 16'd8;

  // median handed to the history unit
  typedef struct packed {
    logic                     push;
    logic signed [TEMP_W-1:0] median;
  } hist_req_t;

  // history unit view of the item in the final stage
  typedef struct packed {
    logic                     full;
    logic                     high_ok;
    logic signed [TEMP_W-1:0] oldest;
  } hist_stat_t;

endpackage

>>> src/mfd_ram.sv
// ---------------------------------------------------------------------------
// Median fire detector - generic RAM
// One write port, two registered read ports, read-before-write.
// ---------------------------------------------------------------------------
module mfd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic                     re_b,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

>>> src/mfd_median.sv
// ---------------------------------------------------------------------------
// Median fire detector - raw window and median select
// Shift line of raw samples and a rank-based median picker.
// ---------------------------------------------------------------------------
module mfd_median #(
  parameter int MEDIAN_LEN = mfd_pkg::MEDIAN_LEN_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             shift_en,
  input  logic signed [mfd_pkg::TEMP_W-1:0] sample,
  output logic                             full,
  output logic signed [mfd_pkg::TEMP_W-1:0] median
);

  localparam int FILL_W = $clog2(MEDIAN_LEN + 1);
  localparam int RK_W   = $clog2(MEDIAN_LEN);
  localparam int MID    = (MEDIAN_LEN - 1) / 2;

  logic signed [mfd_pkg::TEMP_W-1:0] win_r [MEDIAN_LEN];
  logic [FILL_W-1:0]                 fill_r;
  logic [RK_W-1:0]                   rank [MEDIAN_LEN];

  always_ff @(posedge clk) begin
    if (shift_en) begin
      win_r[0] <= sample;
      for (int i = 1; i < MEDIAN_LEN; i++) begin
        win_r[i] <= win_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (shift_en && (fill_r != FILL_W'(MEDIAN_LEN))) begin
      fill_r <= fill_r + 1'b1;
    end
  end

  assign full = (fill_r == FILL_W'(MEDIAN_LEN));

  // rank with index tie-break gives a permutation, so exactly one entry hits MID
  always_comb begin
    median = '0;
    for (int i = 0; i < MEDIAN_LEN; i++) begin
      rank[i] = '0;
      for (int j = 0; j < MEDIAN_LEN; j++) begin
        if ((win_r[j] < win_r[i]) || ((win_r[j] == win_r[i]) && (j < i))) begin
          rank[i] = rank[i] + 1'b1;
        end
      end
      if (rank[i] == RK_W'(MID)) begin
        median = win_r[i];
      end
    end
  end

endmodule

>>> src/mfd_hist.sv
// ---------------------------------------------------------------------------
// Median fire detector - median history
// Ring of medians in RAM with a running high count and a recount sweep.
// ---------------------------------------------------------------------------
module mfd_hist #(
  parameter int HISTORY_LEN = mfd_pkg::HISTORY_LEN_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  mfd_pkg::hist_req_t                req,
  input  logic signed [mfd_pkg::TEMP_W-1:0] thr,
  input  logic [mfd_pkg::NEED_W-1:0]        need,
  input  logic                              thr_wr,
  output logic                              busy,
  output mfd_pkg::hist_stat_t               stat
);

  localparam int PTR_W = $clog2(HISTORY_LEN);
  localparam int CNT_W = $clog2(HISTORY_LEN + 1);
  localparam int CMP_W = (CNT_W > mfd_pkg::NEED_W) ? CNT_W : mfd_pkg::NEED_W;

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_SWEEP = 1'b1;

  logic [PTR_W-1:0] ptr_r;
  logic [PTR_W-1:0] ptr_inc;
  logic [CNT_W-1:0] fill_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [CNT_W-1:0] count_upd;
  logic             q_push_r;
  logic             q_fullb_r;
  logic             q_fulla_r;
  logic signed [mfd_pkg::TEMP_W-1:0] q_med_r;
  logic             st_r;
  logic [PTR_W-1:0] sw_addr_r;
  logic             pend_r;
  logic [PTR_W-1:0] pend_idx_r;

  logic             push_now;
  logic             re_a;
  logic [PTR_W-1:0] raddr_a;
  logic [mfd_pkg::TEMP_W-1:0] rdata_a;
  logic [mfd_pkg::TEMP_W-1:0] rdata_b;
  logic             add_hi;
  logic             sub_hi;
  logic             sweep_hit;

  assign push_now = adv && req.push;
  assign ptr_inc  = (ptr_r == PTR_W'(HISTORY_LEN - 1)) ? '0 : ptr_r + 1'b1;
  assign re_a     = (st_r == ST_SWEEP) || push_now;
  assign raddr_a  = (st_r == ST_SWEEP) ? sw_addr_r : ptr_r;

  // port A: slot about to be overwritten (or sweep), port B: oldest after push
  mfd_ram #(
    .WIDTH (mfd_pkg::TEMP_W),
    .DEPTH (HISTORY_LEN)
  ) u_ram (
    .clk     (clk),
    .we      (push_now),
    .waddr   (ptr_r),
    .wdata   (req.median),
    .re_a    (re_a),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .re_b    (push_now),
    .raddr_b (ptr_inc),
    .rdata_b (rdata_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r    <= '0;
      fill_r   <= '0;
      q_push_r <= 1'b0;
    end else begin
      if (push_now) begin
        ptr_r <= ptr_inc;
        if (fill_r != CNT_W'(HISTORY_LEN)) begin
          fill_r <= fill_r + 1'b1;
        end
      end
      if (adv) begin
        q_push_r <= req.push;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q_fullb_r <= (fill_r == CNT_W'(HISTORY_LEN));
      q_fulla_r <= (fill_r >= CNT_W'(HISTORY_LEN - 1));
      q_med_r   <= req.median;
    end
  end

  assign add_hi    = (q_med_r >= thr);
  assign sub_hi    = q_fullb_r && ($signed(rdata_a) >= thr);
  assign count_upd = count_r + CNT_W'(add_hi) - CNT_W'(sub_hi);
  assign sweep_hit = (CNT_W'(pend_idx_r) < fill_r) && ($signed(rdata_a) >= thr);

  always_comb begin
    count_nxt = count_r;
    priority if (thr_wr) begin
      count_nxt = '0;
    end else if (pend_r) begin
      count_nxt = count_r + CNT_W'(sweep_hit);
    end else if (adv && q_push_r) begin
      count_nxt = count_upd;
    end else begin
      count_nxt = count_r;
    end
  end

  // recount after a threshold change, one entry per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      st_r      <= ST_IDLE;
      sw_addr_r <= '0;
      pend_r    <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (thr_wr) begin
        st_r      <= ST_SWEEP;
        sw_addr_r <= '0;
        pend_r    <= 1'b0;
      end else if (st_r == ST_SWEEP) begin
        pend_r <= 1'b1;
        if (sw_addr_r == PTR_W'(HISTORY_LEN - 1)) begin
          st_r <= ST_IDLE;
        end else begin
          sw_addr_r <= sw_addr_r + 1'b1;
        end
      end else begin
        pend_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_SWEEP) begin
      pend_idx_r <= sw_addr_r;
    end
  end

  assign busy         = (st_r == ST_SWEEP) || pend_r;
  assign stat.full    = q_push_r && q_fulla_r;
  assign stat.high_ok = (CMP_W'(count_upd) >= CMP_W'(need));
  assign stat.oldest  = $signed(rdata_b);

endmodule

>>> src/median_fire_detector_core.sv
// ---------------------------------------------------------------------------
// Median fire detector - top level
// Median filter, high-temperature vote and rate-of-rise alarm.
// ---------------------------------------------------------------------------
// One sample is taken per cycle while neither a held result nor a recount
// holds off input, and each gives one result, presented on the output after
// the history RAM read and the output register. The rate is set by the
// history RAM: one write and two reads per sample, and the high count moves
// by at most one up and one down per sample. Writing high_temp_threshold
// starts a recount of the history that holds off input until it completes.
`include "median_fire_detector_core_assert.svh"

module median_fire_detector_core #(
  parameter int MEDIAN_LEN  = mfd_pkg::MEDIAN_LEN_DEF,
  parameter int HISTORY_LEN = mfd_pkg::HISTORY_LEN_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [mfd_pkg::TEMP_W-1:0]    in_temperature,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_median_valid,
  output logic signed [mfd_pkg::TEMP_W-1:0]    out_median_value,
  output logic                                 out_history_full,
  output logic                                 out_high_temp_alarm,
  output logic                                 out_rise_alarm,
  output logic                                 out_fire_alarm,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mfd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mfd_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int TW = mfd_pkg::TEMP_W;

  logic signed [TW-1:0]         thr_r;
  logic [mfd_pkg::NEED_W-1:0]   need_r;
  logic [mfd_pkg::RISE_W-1:0]   rise_r;

  logic                 adv;
  logic                 in_take;
  logic                 cfg_take;
  logic                 thr_wr;
  logic                 busy;

  logic                 s1_v_r;
  logic signed [TW-1:0] s1_temp_r;
  logic                 s2_v_r;
  logic                 s2_mv_r;
  logic signed [TW-1:0] s2_temp_r;
  logic signed [TW-1:0] s2_med_r;

  logic                 win_full;
  logic signed [TW-1:0] win_med;
  mfd_pkg::hist_req_t   h_req;
  mfd_pkg::hist_stat_t  h_stat;

  logic signed [TW:0]   rise_diff;
  logic                 rise_ok;
  logic                 full_now;
  logic                 hi_now;
  logic                 rise_now;

  logic                 out_valid_r;
  logic                 o_mv_r;
  logic signed [TW-1:0] o_med_r;
  logic                 o_full_r;
  logic                 o_hi_r;
  logic                 o_rise_r;

  // pipeline moves unless a finished result is held up
  assign adv       = !(out_valid_r && out_stall);
  assign in_stall  = !adv || busy;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_take  = cfg_valid && cfg_ready;
  assign thr_wr    = cfg_take && (cfg_index == mfd_pkg::CFG_HIGH_TEMP_THR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= mfd_pkg::HIGH_TEMP_THR_RST;
      need_r <= mfd_pkg::HIGH_CNT_NEED_RST;
      rise_r <= mfd_pkg::RISE_THR_RST;
    end else if (cfg_take) begin
      unique case (cfg_index)
        mfd_pkg::CFG_HIGH_TEMP_THR: thr_r  <= $signed(cfg_data[TW-1:0]);
        mfd_pkg::CFG_HIGH_CNT_NEED: need_r <= cfg_data[mfd_pkg::NEED_W-1:0];
        mfd_pkg::CFG_RISE_THR:      rise_r <= cfg_data[mfd_pkg::RISE_W-1:0];
        default: ;
      endcase
    end
  end

  mfd_median #(
    .MEDIAN_LEN (MEDIAN_LEN)
  ) u_median (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (in_take),
    .sample   (in_temperature),
    .full     (win_full),
    .median   (win_med)
  );

  assign h_req.push   = s1_v_r && win_full;
  assign h_req.median = win_med;

  mfd_hist #(
    .HISTORY_LEN (HISTORY_LEN)
  ) u_hist (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .req    (h_req),
    .thr    (thr_r),
    .need   (need_r),
    .thr_wr (thr_wr),
    .busy   (busy),
    .stat   (h_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_v_r      <= in_take;
      s2_v_r      <= s1_v_r;
      out_valid_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_temp_r <= in_temperature;
    end
    if (adv) begin
      s2_mv_r   <= win_full;
      s2_temp_r <= s1_temp_r;
      s2_med_r  <= win_med;
    end
  end

  // exact difference, compared as signed against the unsigned threshold
  assign rise_diff = {s2_temp_r[TW-1], s2_temp_r} - {h_stat.oldest[TW-1], h_stat.oldest};
  assign rise_ok   = $signed({rise_diff[TW], rise_diff}) >= $signed({2'b00, rise_r});
  assign full_now  = s2_mv_r && h_stat.full;
  assign hi_now    = full_now && h_stat.high_ok;
  assign rise_now  = full_now && rise_ok;

  always_ff @(posedge clk) begin
    if (adv) begin
      o_mv_r   <= s2_mv_r;
      o_med_r  <= s2_mv_r ? s2_med_r : '0;
      o_full_r <= full_now;
      o_hi_r   <= hi_now;
      o_rise_r <= rise_now;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_median_valid    = o_mv_r;
  assign out_median_value    = o_med_r;
  assign out_history_full    = o_full_r;
  assign out_high_temp_alarm = o_hi_r;
  assign out_rise_alarm      = o_rise_r;
  assign out_fire_alarm      = o_hi_r || o_rise_r;

  `MFD_ASSERT_IMPLY(a_full_needs_median, clk, rst_n, out_valid_r && o_full_r, o_mv_r, "history full without a valid median")
  `MFD_ASSERT_IMPLY(a_alarm_needs_full, clk, rst_n, out_valid_r && (o_hi_r || o_rise_r), o_full_r, "alarm raised before history full")
  `MFD_ASSERT_NEXT(a_thr_wr_holds_input, clk, rst_n, thr_wr, in_stall, "input taken during high count recount")

endmodule
